// ===== src/smi_pkg.sv =====
// Package for the integer stack machine core: opcodes, error codes,
// payload structs and the command/status types between controller and datapath.
// No dependencies.
`default_nettype none

package smi_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DSTACK_DEPTH_DEF = 256;
  localparam int RSTACK_DEPTH_DEF = 64;
  localparam int IP_BITS_DEF      = 16;

  // Opcodes
  localparam logic [5:0] OP_NOP   = 6'd0;
  localparam logic [5:0] OP_HLT   = 6'd1;
  localparam logic [5:0] OP_PUSH  = 6'd2;
  localparam logic [5:0] OP_DROP  = 6'd3;
  localparam logic [5:0] OP_DUP   = 6'd4;
  localparam logic [5:0] OP_SWAP  = 6'd5;
  localparam logic [5:0] OP_ISUM  = 6'd6;
  localparam logic [5:0] OP_ISUB  = 6'd7;
  localparam logic [5:0] OP_IMUL  = 6'd8;
  localparam logic [5:0] OP_IDIV  = 6'd9;
  localparam logic [5:0] OP_IMOD  = 6'd10;
  localparam logic [5:0] OP_SHL   = 6'd11;
  localparam logic [5:0] OP_SHR   = 6'd12;
  localparam logic [5:0] OP_BOR   = 6'd13;
  localparam logic [5:0] OP_BAND  = 6'd14;
  localparam logic [5:0] OP_XOR   = 6'd15;
  localparam logic [5:0] OP_BNOT  = 6'd16;
  localparam logic [5:0] OP_LOR   = 6'd17;
  localparam logic [5:0] OP_LAND  = 6'd18;
  localparam logic [5:0] OP_LNOT  = 6'd19;
  localparam logic [5:0] OP_IGT   = 6'd20;
  localparam logic [5:0] OP_ILT   = 6'd21;
  localparam logic [5:0] OP_IGTE  = 6'd22;
  localparam logic [5:0] OP_ILTE  = 6'd23;
  localparam logic [5:0] OP_IEQ   = 6'd24;
  localparam logic [5:0] OP_INEQ  = 6'd25;
  localparam logic [5:0] OP_JMP   = 6'd26;
  localparam logic [5:0] OP_CJMP  = 6'd27;
  localparam logic [5:0] OP_RJMP  = 6'd28;
  localparam logic [5:0] OP_CRJMP = 6'd29;
  localparam logic [5:0] OP_CALL  = 6'd30;
  localparam logic [5:0] OP_RET   = 6'd31;

  // Error codes
  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_DUNDER   = 4'd1;
  localparam logic [3:0] ERR_DOVER    = 4'd2;
  localparam logic [3:0] ERR_RUNDER   = 4'd3;
  localparam logic [3:0] ERR_ROVER    = 4'd4;
  localparam logic [3:0] ERR_ILLEGAL  = 4'd5;
  localparam logic [3:0] ERR_BADPTR   = 4'd6;
  localparam logic [3:0] ERR_STOPPED  = 4'd7;
  localparam logic [3:0] ERR_OPERAND  = 4'd8;
  localparam logic [3:0] ERR_DIVZERO  = 4'd9;

  typedef struct packed {
    logic [5:0]         opcode;
    logic signed [63:0] operand;
  } in_t;

  typedef struct packed {
    logic [3:0]         error_code;
    logic [15:0]        next_ip;
    logic signed [63:0] top_value;
    logic [8:0]         stack_depth;
    logic               running;
  } out_t;

  // Follow-up work an instruction needs after its checks
  typedef enum logic [2:0] {
    CL_DONE, CL_BIN, CL_MDU, CL_REFILL, CL_RET, CL_DUP, CL_SWAP
  } cls_t;

  // One datapath action per cycle
  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_EXEC, CMD_RET_CAP, CMD_B_CAP, CMD_MDU_GO, CMD_WB,
    CMD_TOP_RD, CMD_TOP_CAP, CMD_DUP_RD, CMD_DUP_WR, CMD_SW_RD1, CMD_SW_RD2,
    CMD_SW_WR1, CMD_SW_WR2, CMD_OUT
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic is_mdu;
    logic mdu_done;
    logic loop_last;
    logic depth_nz;
    logic out_busy;
  } ctl_status_t;

  typedef enum logic [1:0] {MDU_MUL, MDU_DIV, MDU_MOD} mdu_op_t;

endpackage

`default_nettype wire

// ===== src/smi_mdu.sv =====
// Bit-serial multiply/divide unit: one bit of product or quotient per cycle.
// Depends on smi_pkg.
`default_nettype none

module smi_mdu import smi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire mdu_op_t     op,
  input  wire logic [63:0] b,     // multiplicand / dividend
  input  wire logic [63:0] a,     // multiplier / divisor
  output logic             done,
  output logic [63:0]      res
);

  logic        busy_r, done_r, neg_r;
  logic [5:0]  cnt_r;
  mdu_op_t     op_r;
  logic [63:0] acc_r, x_r, y_r;
  logic [64:0] rem_r;
  logic [64:0] rem_s;
  logic        fits;

  // Restoring division step
  always_comb begin
    rem_s = {rem_r[63:0], y_r[63]};
    fits  = rem_s >= {1'b0, x_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= op;
        acc_r  <= '0;
        rem_r  <= '0;
        if (op == MDU_MUL) begin
          x_r <= b;
          y_r <= a;
        end else begin
          x_r <= a[63] ? (64'd0 - a) : a;
          y_r <= b[63] ? (64'd0 - b) : b;
        end
        neg_r <= (op == MDU_DIV) ? (a[63] ^ b[63]) : b[63];
      end else if (busy_r) begin
        if (op_r == MDU_MUL) begin
          if (y_r[0]) acc_r <= acc_r + x_r;
          x_r <= {x_r[62:0], 1'b0};
          y_r <= {1'b0, y_r[63:1]};
        end else begin
          rem_r <= fits ? (rem_s - {1'b0, x_r}) : rem_s;
          acc_r <= {acc_r[62:0], fits};
          y_r   <= {y_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Result select: product as is, sign fix-up of quotient and remainder
  always_comb begin
    case (op_r)
      MDU_MUL: res = acc_r;
      MDU_DIV: res = neg_r ? (64'd0 - acc_r) : acc_r;
      default: res = neg_r ? (64'd0 - rem_r[63:0]) : rem_r[63:0];
    endcase
  end

  assign done = done_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("mdu started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mdu done while still busy");
  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 6'd63) |=> done_r) else $error("mdu missed done");

endmodule

`default_nettype wire

// ===== src/smi_dpath.sv =====
// Datapath of the stack machine: data and return stack memories, architectural
// registers, checks, ALU, output register. Depends on smi_pkg and smi_mdu.
`default_nettype none

module smi_dpath import smi_pkg::*; #(
  parameter int DSTACK_DEPTH = DSTACK_DEPTH_DEF,
  parameter int RSTACK_DEPTH = RSTACK_DEPTH_DEF,
  parameter int IP_BITS      = IP_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output ctl_status_t      st,
  input  wire in_t         in_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data
);

  localparam int DAW = $clog2(DSTACK_DEPTH);
  localparam int DDW = $clog2(DSTACK_DEPTH + 1);
  localparam int RAW = (RSTACK_DEPTH > 1) ? $clog2(RSTACK_DEPTH) : 1;
  localparam int RDW = $clog2(RSTACK_DEPTH + 1);
  localparam logic [DDW-1:0]     DMAX   = DDW'(DSTACK_DEPTH);
  localparam logic [RDW-1:0]     RMAX   = RDW'(RSTACK_DEPTH);
  localparam logic [IP_BITS-1:0] IP_MAX = '1;

  // Architectural and work registers
  logic [5:0]         op_r;
  logic [63:0]        opnd_r;
  logic [DDW-1:0]     depth_r, cnt_r;
  logic [RDW-1:0]     rdepth_r;
  logic [IP_BITS-1:0] ip_r;
  logic               run_r, out_valid_r;
  logic [15:0]        plen_r;
  logic [63:0]        top_r, b_r, t_r;
  logic [3:0]         err_r;
  out_t               out_r;

  // Stack memories
  logic [63:0]        dmem [DSTACK_DEPTH];
  logic [IP_BITS-1:0] rmem [RSTACK_DEPTH];
  logic               d_we, r_we;
  logic [DAW-1:0]     d_waddr, d_raddr;
  logic [63:0]        d_wdata, d_rdata;
  logic [RAW-1:0]     r_addr_w, r_addr_r;
  logic [IP_BITS-1:0] r_rdata;

  // Decode and check signals
  logic [DDW-1:0]     opn, free_c, a_top, a_second, a_dsrc, a_ddst, a_lo, a_hi;
  logic [DDW:0]       twice_n;
  logic               op_small, opnd_neg, opnd_zero, is_bin, is_mdu, ok;
  logic [3:0]         err_c;
  cls_t               cls_c;
  logic [31:0]        ip_ext, plen_ext, depth_ext;
  logic [IP_BITS-1:0] ip_inc, ip_abs, ip_rel;
  logic [64:0]        rel_sum;
  logic [63:0]        un_res, alu_res, mdu_res;
  logic [5:0]         sh;
  logic               mdu_done;
  mdu_op_t            mdu_op;

  always_comb begin
    opn       = opnd_r[DDW-1:0];
    op_small  = (opnd_r[63:DDW] == '0);
    opnd_neg  = opnd_r[63];
    opnd_zero = (opnd_r == 64'd0);
    free_c    = DMAX - depth_r;
    twice_n   = {opn, 1'b0};
    ip_ext    = 32'(ip_r);
    plen_ext  = 32'(plen_r);
    depth_ext = 32'(depth_r);
    is_bin    = op_r inside {[OP_ISUM:OP_XOR], OP_LOR, OP_LAND, [OP_IGT:OP_INEQ]};
    is_mdu    = op_r inside {OP_IMUL, OP_IDIV, OP_IMOD};
  end

  // Pointer arithmetic: increment saturates, out-of-range targets go all ones
  always_comb begin
    ip_inc  = (ip_r == IP_MAX) ? IP_MAX : ip_r + 1'b1;
    ip_abs  = (opnd_r[63:IP_BITS] == '0) ? opnd_r[IP_BITS-1:0] : IP_MAX;
    rel_sum = {{(65-IP_BITS){1'b0}}, ip_r} + {opnd_r[63], opnd_r};
    ip_rel  = (rel_sum[64:IP_BITS] == '0) ? rel_sum[IP_BITS-1:0] : IP_MAX;
  end

  // Stack addresses
  always_comb begin
    a_top    = depth_r - 1'b1;
    a_second = depth_r - 2'd2;
    a_hi     = depth_r - opn + cnt_r;
    a_dsrc   = a_hi;
    a_ddst   = depth_r + cnt_r;
    a_lo     = depth_r - twice_n[DDW-1:0] + cnt_r;
  end

  // Checks in priority order; an error commits nothing
  always_comb begin
    err_c = ERR_OK;
    cls_c = CL_DONE;
    if (!run_r) begin
      err_c = ERR_STOPPED;
    end else if (ip_ext >= plen_ext) begin
      err_c = ERR_BADPTR;
    end else begin
      case (op_r)
        OP_NOP, OP_HLT, OP_JMP, OP_RJMP: begin
          cls_c = CL_DONE;
        end
        OP_PUSH: begin
          if (depth_r == DMAX) err_c = ERR_DOVER;
        end
        OP_DROP: begin
          if (opnd_neg) err_c = ERR_OPERAND;
          else if (!op_small || opn > depth_r) err_c = ERR_DUNDER;
          else cls_c = CL_REFILL;
        end
        OP_DUP: begin
          if (opnd_neg || opnd_zero) err_c = ERR_OPERAND;
          else if (!op_small || opn > free_c) err_c = ERR_DOVER;
          else if (opn > depth_r) err_c = ERR_DUNDER;
          else cls_c = CL_DUP;
        end
        OP_SWAP: begin
          if (opnd_neg || opnd_zero) err_c = ERR_OPERAND;
          else if (!op_small || twice_n > {1'b0, depth_r}) err_c = ERR_DUNDER;
          else cls_c = CL_SWAP;
        end
        OP_BNOT, OP_LNOT: begin
          if (depth_r == '0) err_c = ERR_DUNDER;
        end
        OP_CJMP, OP_CRJMP: begin
          if (depth_r == '0) err_c = ERR_DUNDER;
          else cls_c = CL_REFILL;
        end
        OP_CALL: begin
          if (rdepth_r == RMAX) err_c = ERR_ROVER;
        end
        OP_RET: begin
          if (rdepth_r == '0) err_c = ERR_RUNDER;
          else cls_c = CL_RET;
        end
        default: begin
          if (is_bin) begin
            if (depth_r < DDW'(2)) err_c = ERR_DUNDER;
            else if ((op_r == OP_IDIV || op_r == OP_IMOD) && top_r == 64'd0)
              err_c = ERR_DIVZERO;
            else cls_c = is_mdu ? CL_MDU : CL_BIN;
          end else begin
            err_c = ERR_ILLEGAL;
          end
        end
      endcase
    end
    if (err_c != ERR_OK) cls_c = CL_DONE;
    ok = (err_c == ERR_OK);
  end

  // ALU: b is the second entry, a the top
  always_comb begin
    sh     = top_r[5:0];
    un_res = (op_r == OP_BNOT) ? ~top_r : {63'd0, top_r == 64'd0};
    case (op_r)
      OP_ISUM: alu_res = b_r + top_r;
      OP_ISUB: alu_res = b_r - top_r;
      OP_SHL:  alu_res = b_r << sh;
      OP_SHR:  alu_res = $unsigned($signed(b_r) >>> sh);
      OP_BOR:  alu_res = b_r | top_r;
      OP_BAND: alu_res = b_r & top_r;
      OP_XOR:  alu_res = b_r ^ top_r;
      OP_LOR:  alu_res = {63'd0, (b_r != 64'd0) || (top_r != 64'd0)};
      OP_LAND: alu_res = {63'd0, (b_r != 64'd0) && (top_r != 64'd0)};
      OP_IGT:  alu_res = {63'd0, $signed(top_r) < $signed(b_r)};
      OP_ILT:  alu_res = {63'd0, $signed(b_r) < $signed(top_r)};
      OP_IGTE: alu_res = {63'd0, !($signed(b_r) < $signed(top_r))};
      OP_ILTE: alu_res = {63'd0, !($signed(top_r) < $signed(b_r))};
      OP_IEQ:  alu_res = {63'd0, b_r == top_r};
      OP_INEQ: alu_res = {63'd0, b_r != top_r};
      default: alu_res = mdu_res;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_IMUL: mdu_op = MDU_MUL;
      OP_IDIV: mdu_op = MDU_DIV;
      default: mdu_op = MDU_MOD;
    endcase
  end

  smi_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd == CMD_MDU_GO),
    .op    (mdu_op),
    .b     (b_r),
    .a     (top_r),
    .done  (mdu_done),
    .res   (mdu_res)
  );

  // Data stack port control
  always_comb begin
    d_we    = 1'b0;
    d_waddr = a_top[DAW-1:0];
    d_wdata = d_rdata;
    d_raddr = a_top[DAW-1:0];
    case (cmd)
      CMD_EXEC: begin
        d_raddr = a_second[DAW-1:0];
        if (ok && op_r == OP_PUSH) begin
          d_we    = 1'b1;
          d_waddr = depth_r[DAW-1:0];
          d_wdata = opnd_r;
        end else if (ok && (op_r == OP_BNOT || op_r == OP_LNOT)) begin
          d_we    = 1'b1;
          d_wdata = un_res;
        end
      end
      CMD_WB: begin
        d_we    = 1'b1;
        d_waddr = a_second[DAW-1:0];
        d_wdata = alu_res;
      end
      CMD_DUP_RD: d_raddr = a_dsrc[DAW-1:0];
      CMD_DUP_WR: begin
        d_we    = 1'b1;
        d_waddr = a_ddst[DAW-1:0];
      end
      CMD_SW_RD1: d_raddr = a_lo[DAW-1:0];
      CMD_SW_RD2: d_raddr = a_hi[DAW-1:0];
      CMD_SW_WR1: begin
        d_we    = 1'b1;
        d_waddr = a_lo[DAW-1:0];
      end
      CMD_SW_WR2: begin
        d_we    = 1'b1;
        d_waddr = a_hi[DAW-1:0];
        d_wdata = t_r;
      end
      default: d_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    d_rdata <= dmem[d_raddr];
  end

  // Return stack
  always_comb begin
    r_we     = (cmd == CMD_EXEC) && ok && (op_r == OP_CALL);
    r_addr_w = rdepth_r[RAW-1:0];
    r_addr_r = RAW'(rdepth_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (r_we) rmem[r_addr_w] <= ip_inc;
    r_rdata <= rmem[r_addr_r];
  end

  // Register updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      rdepth_r    <= '0;
      ip_r        <= '0;
      run_r       <= 1'b1;
      plen_r      <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) plen_r <= cfg_wdata;
      // a new result beat takes over the register in the same cycle
      if (out_valid_r && out_ready && cmd != CMD_OUT) out_valid_r <= 1'b0;
      case (cmd)
        CMD_LOAD: begin
          op_r   <= in_data.opcode;
          opnd_r <= in_data.operand;
        end
        CMD_EXEC: begin
          err_r <= err_c;
          cnt_r <= '0;
          if (ok) begin
            case (op_r)
              OP_NOP: ip_r <= ip_inc;
              OP_HLT: run_r <= 1'b0;
              OP_PUSH: begin
                top_r   <= opnd_r;
                depth_r <= depth_r + 1'b1;
                ip_r    <= ip_inc;
              end
              OP_DROP: begin
                depth_r <= depth_r - opn;
                ip_r    <= ip_inc;
                if (depth_r == opn) top_r <= '0;
              end
              OP_BNOT, OP_LNOT: begin
                top_r <= un_res;
                ip_r  <= ip_inc;
              end
              OP_JMP:  ip_r <= ip_abs;
              OP_RJMP: ip_r <= ip_rel;
              OP_CJMP, OP_CRJMP: begin
                depth_r <= depth_r - 1'b1;
                if (top_r != 64'd0) ip_r <= (op_r == OP_CJMP) ? ip_abs : ip_rel;
                else ip_r <= ip_inc;
                if (depth_r == DDW'(1)) top_r <= '0;
              end
              OP_CALL: begin
                rdepth_r <= rdepth_r + 1'b1;
                ip_r     <= ip_abs;
              end
              default: ip_r <= ip_r;
            endcase
          end
        end
        CMD_RET_CAP: begin
          ip_r     <= r_rdata;
          rdepth_r <= rdepth_r - 1'b1;
        end
        CMD_B_CAP: b_r <= d_rdata;
        CMD_WB: begin
          top_r   <= alu_res;
          depth_r <= depth_r - 1'b1;
          ip_r    <= ip_inc;
        end
        CMD_TOP_CAP: top_r <= d_rdata;
        CMD_DUP_WR: begin
          cnt_r <= cnt_r + 1'b1;
          if (st.loop_last) begin
            depth_r <= depth_r + opn;
            ip_r    <= ip_inc;
          end
        end
        CMD_SW_RD2: t_r <= d_rdata;
        CMD_SW_WR2: begin
          cnt_r <= cnt_r + 1'b1;
          if (st.loop_last) ip_r <= ip_inc;
        end
        CMD_OUT: begin
          out_valid_r          <= 1'b1;
          out_r.error_code     <= err_r;
          out_r.next_ip        <= ip_ext[15:0];
          out_r.top_value      <= top_r;
          out_r.stack_depth    <= depth_ext[8:0];
          out_r.running        <= run_r;
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    st.cls       = cls_c;
    st.is_mdu    = is_mdu;
    st.mdu_done  = mdu_done;
    st.loop_last = (cnt_r == opn - 1'b1);
    st.depth_nz  = (depth_r != '0);
    st.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DMAX) else $error("data stack depth beyond capacity");
  a_rdepth_max: assert property (@(posedge clk) disable iff (!rst_n)
    rdepth_r <= RMAX) else $error("return stack depth beyond capacity");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |=> !run_r) else $error("run flag came back without reset");

endmodule

`default_nettype wire

// ===== src/smi_ctrl.sv =====
// Controller state machine of the stack machine: sequences datapath commands.
// Depends on smi_pkg.
`default_nettype none

module smi_ctrl import smi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire ctl_status_t st,
  output cmd_t             cmd
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_EXEC   = 16'h0002,
    S_RETCAP = 16'h0004,
    S_BCAP   = 16'h0008,
    S_MGO    = 16'h0010,
    S_MWAIT  = 16'h0020,
    S_WB     = 16'h0040,
    S_TOPRD  = 16'h0080,
    S_TOPCAP = 16'h0100,
    S_DUPRD  = 16'h0200,
    S_DUPWR  = 16'h0400,
    S_SRD1   = 16'h0800,
    S_SRD2   = 16'h1000,
    S_SWR1   = 16'h2000,
    S_SWR2   = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd = CMD_EXEC;
        case (st.cls)
          CL_BIN, CL_MDU: state_nxt = S_BCAP;
          CL_REFILL:      state_nxt = S_TOPRD;
          CL_RET:         state_nxt = S_RETCAP;
          CL_DUP:         state_nxt = S_DUPRD;
          CL_SWAP:        state_nxt = S_SRD1;
          default:        state_nxt = S_DONE;
        endcase
      end
      S_RETCAP: begin
        cmd       = CMD_RET_CAP;
        state_nxt = S_DONE;
      end
      S_BCAP: begin
        cmd       = CMD_B_CAP;
        state_nxt = st.is_mdu ? S_MGO : S_WB;
      end
      S_MGO: begin
        cmd       = CMD_MDU_GO;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (st.mdu_done) state_nxt = S_WB;
      end
      S_WB: begin
        cmd       = CMD_WB;
        state_nxt = S_DONE;
      end
      S_TOPRD: begin
        cmd       = CMD_TOP_RD;
        state_nxt = st.depth_nz ? S_TOPCAP : S_DONE;
      end
      S_TOPCAP: begin
        cmd       = CMD_TOP_CAP;
        state_nxt = S_DONE;
      end
      S_DUPRD: begin
        cmd       = CMD_DUP_RD;
        state_nxt = S_DUPWR;
      end
      S_DUPWR: begin
        cmd       = CMD_DUP_WR;
        state_nxt = st.loop_last ? S_DONE : S_DUPRD;
      end
      S_SRD1: begin
        cmd       = CMD_SW_RD1;
        state_nxt = S_SRD2;
      end
      S_SRD2: begin
        cmd       = CMD_SW_RD2;
        state_nxt = S_SWR1;
      end
      S_SWR1: begin
        cmd       = CMD_SW_WR1;
        state_nxt = S_SWR2;
      end
      S_SWR2: begin
        cmd       = CMD_SW_WR2;
        state_nxt = st.loop_last ? S_TOPRD : S_SRD1;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd       = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_EXEC) else $error("accept did not start exec");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st.out_busy) |=> state_r == S_DONE)
    else $error("result dropped while output busy");
  a_mwait_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWAIT && st.mdu_done) |=> state_r == S_WB)
    else $error("mdu result not written back");

endmodule

`default_nettype wire

// ===== src/stack_machine_integer_core.sv =====
// Integer stack machine core, top level: controller plus datapath.
// Depends on smi_pkg, smi_ctrl, smi_dpath (which uses smi_mdu).
//
// Usage: each beat on the in_ channel (valid/ready) carries one fetched
// instruction (opcode, operand). For every accepted beat exactly one result
// beat leaves on the out_ channel: error code, pointer after the step, top of
// the data stack, its depth and the running flag. program_length is written
// through cfg_we/cfg_wdata while the core is idle.
// Steps per item: pointer, push, unary and call ops and all errors go from
// execute to output; ret adds a return-stack capture; binary ops capture the
// second entry and write back; drop and conditional jumps reread the top if
// the stack is not empty; dup n copies entry by entry, swap n swaps pair by
// pair and then rereads the top, via the data stack memory's one read and
// one write port; multiply, divide and modulo wait for the one-bit-per-cycle
// multiply/divide unit. One item is in work at a time; the next beat can be
// taken in the cycle after the result is registered.
// Reset (synchronous, rst_n low): stacks empty, pointer 0, running, program
// length 0. The result register holds a finished beat while the receiver
// stalls; the core accepts the next item meanwhile and waits before
// presenting its result.
`default_nettype none

module stack_machine_integer_core import smi_pkg::*; #(
  parameter int DSTACK_DEPTH = DSTACK_DEPTH_DEF,
  parameter int RSTACK_DEPTH = RSTACK_DEPTH_DEF,
  parameter int IP_BITS      = IP_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  cmd_t        cmd;
  ctl_status_t st;

  smi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  smi_dpath #(
    .DSTACK_DEPTH (DSTACK_DEPTH),
    .RSTACK_DEPTH (RSTACK_DEPTH),
    .IP_BITS      (IP_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
